[hdl/tkf_pkg.sv]
// shared constants, types and controller codes for the top-k frequent values core
package tkf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_K       = 16;
    localparam int KI_W        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int K_W         = $clog2(MAX_K + 1);
    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 16;
    localparam int VALUE_W     = 32;
    localparam int ENTRY_W     = VALUE_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_APPEND,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic ptr_clear;
        logic ptr_inc;
        logic count_up;
        logic append;
        logic list_clear;
        logic list_insert;
        logic emit_pop;
        logic set_clear;
    } cmd_t;

    typedef struct packed {
        logic used_zero;
        logic hit;
        logic ptr_last;
        logic set_end;
        logic emit_last;
    } status_t;

endpackage

[hdl/tkf_ram.sv]
// generic single-write, single-read ram with registered read data
module tkf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/tkf_datapath.sv]
// datapath: value table, ranked result list and output word
module tkf_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tkf_pkg::cmd_t               cmd,
    output tkf_pkg::status_t            status,
    input  logic [tkf_pkg::VALUE_W-1:0] in_value,
    input  logic                        in_last,
    input  logic                        cfg_we,
    input  logic [tkf_pkg::CFG_W-1:0]   cfg_wdata,
    output logic [tkf_pkg::VALUE_W-1:0] out_value,
    output logic                        out_last,
    output logic                        out_overflow
);

    logic [tkf_pkg::VALUE_W-1:0] value_reg;
    logic                        last_reg;
    logic [tkf_pkg::IDX_W-1:0]   ptr_reg;
    logic [tkf_pkg::USED_W-1:0]  used_reg;
    logic                        overflow_reg;
    logic [tkf_pkg::CFG_W-1:0]   top_reg;
    logic [tkf_pkg::K_W-1:0]     fill_reg;
    logic [tkf_pkg::COUNT_W-1:0] slot_cnt_reg [tkf_pkg::MAX_K];
    logic [tkf_pkg::VALUE_W-1:0] slot_val_reg [tkf_pkg::MAX_K];

    logic                        ram_we;
    logic [tkf_pkg::IDX_W-1:0]   ram_waddr;
    logic [tkf_pkg::ENTRY_W-1:0] ram_wdata;
    logic [tkf_pkg::ENTRY_W-1:0] ram_rdata;
    logic [tkf_pkg::COUNT_W-1:0] rd_count;
    logic [tkf_pkg::VALUE_W-1:0] rd_value;
    logic [tkf_pkg::COUNT_W-1:0] count_inc;
    logic [tkf_pkg::K_W-1:0]     k_eff;
    logic [tkf_pkg::MAX_K-1:0]   ge;
    logic                        do_insert;
    logic [tkf_pkg::K_W-1:0]     k_m1;
    logic [tkf_pkg::K_W-1:0]     fill_m1;

    assign rd_value  = ram_rdata[tkf_pkg::VALUE_W-1:0];
    assign rd_count  = ram_rdata[tkf_pkg::ENTRY_W-1:tkf_pkg::VALUE_W];
    assign count_inc = (rd_count == tkf_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {count_inc, rd_value};
        if (cmd.count_up)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.append && used_reg != tkf_pkg::USED_W'(tkf_pkg::TABLE_DEPTH))
        begin
            ram_we    = 1'b1;
            ram_waddr = used_reg[tkf_pkg::IDX_W-1:0];
            ram_wdata = {tkf_pkg::COUNT_W'(1), value_reg};
        end
    end

    tkf_ram #(
        .WIDTH (tkf_pkg::ENTRY_W),
        .DEPTH (tkf_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // zero means one, anything above the list size means the list size
    always_comb
    begin
        if (top_reg == '0)
        begin
            k_eff = tkf_pkg::K_W'(1);
        end
        else if (tkf_pkg::K_W'(top_reg) > tkf_pkg::K_W'(tkf_pkg::MAX_K))
        begin
            k_eff = tkf_pkg::K_W'(tkf_pkg::MAX_K);
        end
        else
        begin
            k_eff = tkf_pkg::K_W'(top_reg);
        end
    end

    // list is kept highest rank first; a later entry goes behind equal counts
    always_comb
    begin
        for (int j = 0; j < tkf_pkg::MAX_K; j++)
        begin
            ge[j] = (tkf_pkg::K_W'(j) < fill_reg) && (slot_cnt_reg[j] >= rd_count);
        end
    end

    assign k_m1      = k_eff - 1'b1;
    assign fill_m1   = fill_reg - 1'b1;
    assign do_insert = (fill_reg < k_eff) || !ge[k_m1[tkf_pkg::KI_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            overflow_reg <= 1'b0;
            fill_reg     <= '0;
            top_reg      <= tkf_pkg::CFG_W'(1);
            ptr_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                top_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                last_reg <= in_last;
            end
            if (cmd.ptr_clear)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.set_clear)
            begin
                used_reg     <= '0;
                overflow_reg <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (used_reg != tkf_pkg::USED_W'(tkf_pkg::TABLE_DEPTH))
                begin
                    used_reg <= used_reg + 1'b1;
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.list_clear)
            begin
                fill_reg <= '0;
            end
            else if (cmd.list_insert && do_insert && fill_reg < k_eff)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (cmd.emit_pop)
            begin
                fill_reg <= fill_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= in_value;
        end
        if (cmd.list_insert && do_insert)
        begin
            for (int j = 0; j < tkf_pkg::MAX_K; j++)
            begin
                if (!ge[j])
                begin
                    if (j == 0 || ge[(j > 0) ? j - 1 : 0])
                    begin
                        slot_cnt_reg[j] <= rd_count;
                        slot_val_reg[j] <= rd_value;
                    end
                    else
                    begin
                        slot_cnt_reg[j] <= slot_cnt_reg[(j > 0) ? j - 1 : 0];
                        slot_val_reg[j] <= slot_val_reg[(j > 0) ? j - 1 : 0];
                    end
                end
            end
        end
    end

    assign status.used_zero = (used_reg == '0);
    assign status.hit       = (rd_value == value_reg);
    assign status.ptr_last  = ((tkf_pkg::USED_W'(ptr_reg) + 1'b1) == used_reg);
    assign status.set_end   = last_reg;
    assign status.emit_last = (fill_reg == tkf_pkg::K_W'(1));

    // lowest rank sits at the tail of the list
    assign out_value    = slot_val_reg[fill_m1[tkf_pkg::KI_W-1:0]];
    assign out_last     = status.emit_last;
    assign out_overflow = overflow_reg;

endmodule

[hdl/tkf_ctrl.sv]
// controller state machine: table scan, ranking walk and result emission
module tkf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tkf_pkg::status_t status,
    output tkf_pkg::cmd_t    cmd
);

    tkf_pkg::state_t state_reg;
    tkf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.used_zero ? tkf_pkg::ST_APPEND : tkf_pkg::ST_SCAN_RD;
                end
            end
            tkf_pkg::ST_SCAN_RD:
            begin
                state_next = tkf_pkg::ST_SCAN_CMP;
            end
            tkf_pkg::ST_SCAN_CMP:
            begin
                if (status.hit)
                begin
                    state_next = status.set_end ? tkf_pkg::ST_WALK_RD : tkf_pkg::ST_IDLE;
                end
                else if (status.ptr_last)
                begin
                    state_next = tkf_pkg::ST_APPEND;
                end
                else
                begin
                    state_next = tkf_pkg::ST_SCAN_RD;
                end
            end
            tkf_pkg::ST_APPEND:
            begin
                state_next = status.set_end ? tkf_pkg::ST_WALK_RD : tkf_pkg::ST_IDLE;
            end
            tkf_pkg::ST_WALK_RD:
            begin
                state_next = tkf_pkg::ST_WALK_CMP;
            end
            tkf_pkg::ST_WALK_CMP:
            begin
                state_next = status.ptr_last ? tkf_pkg::ST_EMIT : tkf_pkg::ST_WALK_RD;
            end
            tkf_pkg::ST_EMIT:
            begin
                if (out_ready && status.emit_last)
                begin
                    state_next = tkf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            tkf_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.capture   = in_valid;
                cmd.ptr_clear = in_valid;
            end
            tkf_pkg::ST_SCAN_RD:
            begin
            end
            tkf_pkg::ST_SCAN_CMP:
            begin
                if (status.hit)
                begin
                    cmd.count_up   = 1'b1;
                    cmd.ptr_clear  = status.set_end;
                    cmd.list_clear = status.set_end;
                end
                else if (!status.ptr_last)
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            tkf_pkg::ST_APPEND:
            begin
                cmd.append     = 1'b1;
                cmd.ptr_clear  = status.set_end;
                cmd.list_clear = status.set_end;
            end
            tkf_pkg::ST_WALK_RD:
            begin
            end
            tkf_pkg::ST_WALK_CMP:
            begin
                cmd.list_insert = 1'b1;
                cmd.ptr_inc     = !status.ptr_last;
            end
            tkf_pkg::ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.emit_pop  = out_ready;
                cmd.set_clear = out_ready && status.emit_last;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hdl/top_k_frequent_values_core.sv]
// top level of the top-k frequent values core
//
//  port group   dir  tdata                        tuser                 tlast
//  s_axis       in   [31:0] sample_value          -                     set_end
//  m_axis       out  [31:0] frequent_value        [0] table_overflowed  run_end
//  cfg          in   cfg_wdata[4:0] top_count     -                     -
//
// a word is handled by a linear scan of the table ram (read, then compare, per entry)
// plus an append on a miss; the final word adds a ranking walk over every stored
// entry, then one result word per cycle while m_tready is high
// no clearing pass after reset; s_tready is low from a word's acceptance until it
// is fully processed and, for a final word, until the last result is taken
module top_k_frequent_values_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] frequent_value
    output logic        m_tuser,   // [0] table_overflowed
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    tkf_pkg::cmd_t    cmd;
    tkf_pkg::status_t status;

    tkf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tkf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_value     (s_tdata),
        .in_last      (s_tlast),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_value    (m_tdata),
        .out_last     (m_tlast),
        .out_overflow (m_tuser)
    );

endmodule

[hdl/tkf_checker.sv]
// port-level checks for the top-k frequent values core, bound to the top level
module tkf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // results and new input words never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while results pending");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed under stall");

    // a run continues until its last word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tuser))
        else $error("run ended without last word");

    // input reopens right after the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("input not reopened after run");

endmodule

bind top_k_frequent_values_core tkf_checker u_tkf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
